@@ src/ccp_pkg.sv @@
// Shared types and character constants for the clock command parser.
// No dependencies; ccp_result_if and the top level use this package.
package ccp_pkg;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_START_SW  = 2'd1,
    CMD_READ_CLK  = 2'd2,
    CMD_SET_CLK   = 2'd3
  } command_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_CASE  = 8'h20;

  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;

  localparam logic [4:0] HOUR_LIMIT = 5'd24;

endpackage

@@ src/ccp_char_if.sv @@
// Valid/ready channel that carries one received character per transaction.
// Depends on nothing beyond plain logic types.
interface ccp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

@@ src/ccp_result_if.sv @@
// Valid/ready channel that carries one parser result per transaction.
// Depends on ccp_pkg for the command code type.
interface ccp_result_if;
  logic               valid;
  logic               ready;
  ccp_pkg::command_t  command;
  logic [4:0]         set_hour;
  logic [5:0]         set_minute;
  logic [5:0]         set_second;
  logic [3:0]         set_tenth;
  logic               stop_stopwatch;
  logic               line_valid;

  modport source (output valid, output command, output set_hour, output set_minute,
                  output set_second, output set_tenth, output stop_stopwatch,
                  output line_valid, input ready);
  modport sink   (input valid, input command, input set_hour, input set_minute,
                  input set_second, input set_tenth, input stop_stopwatch,
                  input line_valid, output ready);
endinterface

@@ src/clock_command_parser_top.sv @@
// Top level of the clock command parser: line state machine and result register.
// Depends on ccp_pkg, ccp_char_if and ccp_result_if.

// The parser takes one console character per transaction on the chars channel
// and returns exactly one result transaction per character on the results
// channel. It recognizes the case-insensitive commands GO, TIME and
// "SET HHMMSSt", checks each digit against its position (hour below 24,
// minute and second tens digits 0 to 5), and reports the command when the
// carriage return arrives. Any character received while the stopwatch runs
// raises stop_stopwatch on its own result. The next-state logic sits between
// the parser state registers and a single output register, so a new
// character is accepted in every cycle as long as the results channel takes
// the pending result in that same cycle or the output register is empty. The
// result is registered and becomes valid in the cycle after its character is
// accepted.
module clock_command_parser_top (
  input  logic              clk,
  input  logic              rst,
  ccp_char_if.sink          chars,
  ccp_result_if.source      results
);
  import ccp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'd0,
    ST_INVALID = 5'd1,
    ST_G1      = 5'd2,
    ST_O2      = 5'd3,
    ST_T1      = 5'd4,
    ST_I2      = 5'd5,
    ST_M3      = 5'd6,
    ST_E4      = 5'd7,
    ST_S1      = 5'd8,
    ST_E2      = 5'd9,
    ST_T3      = 5'd10,
    ST_SP4     = 5'd11,
    ST_H1      = 5'd12,
    ST_H2      = 5'd13,
    ST_MI1     = 5'd14,
    ST_MI2     = 5'd15,
    ST_SE1     = 5'd16,
    ST_SE2     = 5'd17,
    ST_TN1     = 5'd18
  } state_t;

  // Parser state.
  state_t     state;
  logic [4:0] hour_acc;
  logic [5:0] minute_acc;
  logic [5:0] second_acc;
  logic [3:0] tenth_acc;
  logic       stopwatch_running;

  // Output register.
  logic       out_valid;
  command_t   out_command;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;
  logic [3:0] out_tenth;
  logic       out_stop;
  logic       out_line_valid;

  // Next values.
  state_t     state_next;
  logic [4:0] hour_acc_next;
  logic [5:0] minute_acc_next;
  logic [5:0] second_acc_next;
  logic [3:0] tenth_acc_next;
  logic       stopwatch_running_next;
  command_t   command_next;

  logic       accept;
  logic [7:0] upper;
  logic [3:0] digit;
  logic [6:0] digit_x10;
  logic [4:0] hour_sum;
  logic [5:0] minute_sum;
  logic [5:0] second_sum;

  // The output register frees up when it is empty or drained this cycle.
  assign chars.ready = !out_valid || results.ready;
  assign accept      = chars.valid && chars.ready;

  assign digit     = chars.char_code[3:0];
  assign digit_x10 = {3'd0, digit} * 7'd10;
  assign hour_sum   = hour_acc + {1'b0, digit};
  assign minute_sum = minute_acc + {2'b00, digit};
  assign second_sum = second_acc + {2'b00, digit};

  // Fold lower-case letters onto upper case.
  assign upper = (chars.char_code >= CH_LC_A && chars.char_code <= CH_LC_Z) ?
                 (chars.char_code - CH_CASE) : chars.char_code;

  always_comb begin
    state_next             = ST_INVALID;
    hour_acc_next          = hour_acc;
    minute_acc_next        = minute_acc;
    second_acc_next        = second_acc;
    tenth_acc_next         = tenth_acc;
    stopwatch_running_next = 1'b0;
    command_next           = CMD_NONE;

    if (chars.char_code == CH_CR) begin
      state_next = ST_IDLE;
      case (state)
        ST_O2: begin
          command_next           = CMD_START_SW;
          stopwatch_running_next = 1'b1;
        end
        ST_E4:   command_next = CMD_READ_CLK;
        ST_TN1:  command_next = CMD_SET_CLK;
        default: command_next = CMD_NONE;
      endcase
    end else if (chars.char_code == CH_SPACE) begin
      state_next = (state == ST_T3) ? ST_SP4 : ST_INVALID;
    end else if (chars.char_code inside {[CH_ZERO:CH_NINE]}) begin
      // Each digit position but the tenths has its own range check.
      case (state)
        ST_SP4: begin
          if (digit <= 4'd2) begin
            hour_acc_next = digit_x10[4:0];
            state_next    = ST_H1;
          end
        end
        ST_H1: begin
          // The hour units digit is kept even when it makes the hour too large.
          hour_acc_next = hour_sum;
          state_next    = (hour_sum < HOUR_LIMIT) ? ST_H2 : ST_INVALID;
        end
        ST_H2: begin
          if (digit <= 4'd5) begin
            minute_acc_next = digit_x10[5:0];
            state_next      = ST_MI1;
          end
        end
        ST_MI1: begin
          minute_acc_next = minute_sum;
          state_next      = (minute_sum < 6'd60) ? ST_MI2 : ST_INVALID;
        end
        ST_MI2: begin
          if (digit <= 4'd5) begin
            second_acc_next = digit_x10[5:0];
            state_next      = ST_SE1;
          end
        end
        ST_SE1: begin
          second_acc_next = second_sum;
          state_next      = (second_sum < 6'd60) ? ST_SE2 : ST_INVALID;
        end
        ST_SE2: begin
          tenth_acc_next = digit;
          state_next     = ST_TN1;
        end
        default: state_next = ST_INVALID;
      endcase
    end else begin
      case (upper)
        CH_G: state_next = (state == ST_IDLE) ? ST_G1 : ST_INVALID;
        CH_O: state_next = (state == ST_G1) ? ST_O2 : ST_INVALID;
        CH_S: state_next = (state == ST_IDLE) ? ST_S1 : ST_INVALID;
        CH_I: state_next = (state == ST_T1) ? ST_I2 : ST_INVALID;
        CH_M: state_next = (state == ST_I2) ? ST_M3 : ST_INVALID;
        CH_E: begin
          if (state == ST_M3) begin
            state_next = ST_E4;
          end else if (state == ST_S1) begin
            state_next = ST_E2;
          end
        end
        CH_T: begin
          if (state == ST_IDLE) begin
            state_next = ST_T1;
          end else if (state == ST_E2) begin
            state_next = ST_T3;
          end
        end
        default: state_next = ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      hour_acc          <= '0;
      minute_acc        <= '0;
      second_acc        <= '0;
      tenth_acc         <= '0;
      stopwatch_running <= 1'b0;
      out_valid         <= 1'b0;
    end else if (accept) begin
      state             <= state_next;
      hour_acc          <= hour_acc_next;
      minute_acc        <= minute_acc_next;
      second_acc        <= second_acc_next;
      tenth_acc         <= tenth_acc_next;
      stopwatch_running <= stopwatch_running_next;
      out_valid         <= 1'b1;
      out_command       <= command_next;
      // The set fields carry the time only for a set-clock command.
      out_hour          <= (command_next == CMD_SET_CLK) ? hour_acc : 5'd0;
      out_minute        <= (command_next == CMD_SET_CLK) ? minute_acc : 6'd0;
      out_second        <= (command_next == CMD_SET_CLK) ? second_acc : 6'd0;
      out_tenth         <= (command_next == CMD_SET_CLK) ? tenth_acc : 4'd0;
      out_stop          <= stopwatch_running;
      out_line_valid    <= (state_next != ST_INVALID);
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid          = out_valid;
  assign results.command        = out_command;
  assign results.set_hour       = out_hour;
  assign results.set_minute     = out_minute;
  assign results.set_second     = out_second;
  assign results.set_tenth      = out_tenth;
  assign results.stop_stopwatch = out_stop;
  assign results.line_valid     = out_line_valid;

endmodule

@@ bench/tb_clock_command_parser_top.sv @@
// Self-checking testbench for clock_command_parser_top: typed console lines in,
// one parser result per character out, checked against a cycle-free predictor.
// Depends on ccp_pkg, ccp_char_if, ccp_result_if and the parser top level.
`timescale 1ns / 1ps

module tb_clock_command_parser_top;
  import ccp_pkg::*;

  // Cycles with no transaction on either channel before the run is abandoned.
  // The parser holds a result for every character in its output register, so
  // even the heaviest idling phase never comes close to this.
  localparam int QUIET_LIMIT  = 2000;
  // Cycles that the run lingers after the last result, to catch stray results.
  localparam int DRAIN_CYCLES = 8;
  // Least number of characters queued in each phase, the directed opening included.
  localparam int PHASE_CHARS  = 95;

  // Position of the line parser within the three commands. The codes mirror
  // the order in which the parser walks through GO, TIME and SET HHMMSSt.
  typedef enum logic [4:0] {
    LS_IDLE, LS_INVALID,
    LS_G1, LS_O2,
    LS_T1, LS_I2, LS_M3, LS_E4,
    LS_S1, LS_E2, LS_T3, LS_SP4,
    LS_H1, LS_H2, LS_MI1, LS_MI2, LS_SE1, LS_SE2, LS_TN1
  } line_state_t;

  // One result transaction, as the parser should present it.
  typedef struct packed {
    command_t   command;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [3:0] tenth;
    logic       stop;
    logic       line_valid;
  } char_result_t;

  logic clk;
  logic rst;

  ccp_char_if   chars ();
  ccp_result_if results ();

  clock_command_parser_top dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars.sink),
    .results (results.source)
  );

  // Characters waiting to be offered, and results waiting to come back.
  logic [7:0]   typed_chars[$];
  char_result_t pending_results[$];

  // The predictor's own copy of the parser state.
  line_state_t line_pos;
  logic [4:0]  hour_acc;
  logic [5:0]  minute_acc;
  logic [5:0]  second_acc;
  logic [3:0]  tenth_acc;
  logic        watch_running;

  int sender_idle_pct;
  int receiver_stall_pct;
  int error_count;
  int quiet_cycles;

  // Walks one character through the line parser and returns the result it
  // should produce. Updates the predictor state as a side effect.
  function automatic char_result_t parse_char(input logic [7:0] ch);
    char_result_t r;
    line_state_t  st;
    logic [7:0]   up;
    logic [3:0]   d;
    r = '0;
    st = line_pos;
    // Whatever the character is, it stops a running stopwatch first.
    if (watch_running) begin
      watch_running = 1'b0;
      r.stop = 1'b1;
    end
    if (ch == CH_CR) begin
      case (st)
        LS_O2: begin
          r.command = CMD_START_SW;
          watch_running = 1'b1;
        end
        LS_E4:   r.command = CMD_READ_CLK;
        LS_TN1:  r.command = CMD_SET_CLK;
        default: r.command = CMD_NONE;
      endcase
      st = LS_IDLE;
    end else if (ch == CH_SPACE) begin
      st = (st == LS_T3) ? LS_SP4 : LS_INVALID;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d = 4'(ch - CH_ZERO);
      case (st)
        LS_SP4: begin
          if (d > 4'd2) begin
            st = LS_INVALID;
          end else begin
            hour_acc = 5'(d * 10);
            st = LS_H1;
          end
        end
        LS_H1: begin
          // The units digit is added even when it pushes the hour past 23.
          hour_acc = hour_acc + 5'(d);
          st = (hour_acc < HOUR_LIMIT) ? LS_H2 : LS_INVALID;
        end
        LS_H2: begin
          if (d > 4'd5) begin
            st = LS_INVALID;
          end else begin
            minute_acc = 6'(d * 10);
            st = LS_MI1;
          end
        end
        LS_MI1: begin
          minute_acc = minute_acc + 6'(d);
          st = (minute_acc < 6'd60) ? LS_MI2 : LS_INVALID;
        end
        LS_MI2: begin
          if (d > 4'd5) begin
            st = LS_INVALID;
          end else begin
            second_acc = 6'(d * 10);
            st = LS_SE1;
          end
        end
        LS_SE1: begin
          second_acc = second_acc + 6'(d);
          st = (second_acc < 6'd60) ? LS_SE2 : LS_INVALID;
        end
        LS_SE2: begin
          tenth_acc = d;
          st = LS_TN1;
        end
        default: st = LS_INVALID;
      endcase
    end else begin
      // Letters are matched case-insensitively; anything else is invalid.
      up = (ch >= CH_LC_A && ch <= CH_LC_Z) ? ch - CH_CASE : ch;
      case (up)
        CH_G:    st = (st == LS_IDLE) ? LS_G1 : LS_INVALID;
        CH_O:    st = (st == LS_G1) ? LS_O2 : LS_INVALID;
        CH_S:    st = (st == LS_IDLE) ? LS_S1 : LS_INVALID;
        CH_I:    st = (st == LS_T1) ? LS_I2 : LS_INVALID;
        CH_M:    st = (st == LS_I2) ? LS_M3 : LS_INVALID;
        CH_E:    st = (st == LS_M3) ? LS_E4 : (st == LS_S1) ? LS_E2 : LS_INVALID;
        CH_T:    st = (st == LS_IDLE) ? LS_T1 : (st == LS_E2) ? LS_T3 : LS_INVALID;
        default: st = LS_INVALID;
      endcase
    end
    line_pos = st;
    if (r.command == CMD_SET_CLK) begin
      r.hour   = hour_acc;
      r.minute = minute_acc;
      r.second = second_acc;
      r.tenth  = tenth_acc;
    end
    r.line_valid = (st != LS_INVALID);
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ns  MISMATCH  %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Queues the characters of a string as they stand.
  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) typed_chars.push_back(s[i]);
  endtask

  // Queues one random line. Most lines are real commands in random case and,
  // for SET, with random digits, so that the parser gets deep into its states.
  // Some are then damaged (a byte replaced, cut short, or an extra byte after
  // the command) and a few are plain noise, with or without carriage return.
  task automatic queue_random_line();
    logic [7:0] line[$];
    logic [7:0] c;
    string      word;
    int         kind;
    int         n;
    int         i;
    int         hr;
    int         mn;
    int         sc;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      n = $urandom_range(1, 6);
      repeat (n) line.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 2))
        0:       word = "GO";
        1:       word = "TIME";
        default: word = "SET ";
      endcase
      for (i = 0; i < word.len(); i++) begin
        c = word[i];
        if (c != CH_SPACE && $urandom_range(0, 1) == 1) c = c + CH_CASE;
        line.push_back(c);
      end
      if (word == "SET ") begin
        // Now and then the digits leave their legal ranges: hours of 24 and
        // up, and minute or second tens digits above five.
        if ($urandom_range(0, 5) == 0) begin
          hr = $urandom_range(0, 39);
          mn = $urandom_range(0, 99);
          sc = $urandom_range(0, 99);
        end else begin
          hr = $urandom_range(0, 23);
          mn = $urandom_range(0, 59);
          sc = $urandom_range(0, 59);
        end
        line.push_back(8'(CH_ZERO + hr / 10));
        line.push_back(8'(CH_ZERO + hr % 10));
        line.push_back(8'(CH_ZERO + mn / 10));
        line.push_back(8'(CH_ZERO + mn % 10));
        line.push_back(8'(CH_ZERO + sc / 10));
        line.push_back(8'(CH_ZERO + sc % 10));
        line.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      case ($urandom_range(0, 9))
        0: line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
        1: begin
          n = $urandom_range(0, line.size() - 1);
          while (line.size() > n) void'(line.pop_back());
        end
        2: line.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end
    if (kind != 0) line.push_back(CH_CR);
    foreach (line[k]) typed_chars.push_back(line[k]);
  endtask

  // Free-running clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sender. A new character is offered only once the previous transaction
  // has gone through, so valid never drops while a character is on offer.
  // The idle roll is taken only when a slot is free, which puts gaps between
  // characters at random points of every command.
  always @(posedge clk) begin
    if (rst) begin
      chars.valid     <= 1'b0;
      chars.char_code <= 8'h00;
    end else if (!chars.valid || chars.ready) begin
      if (typed_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        chars.valid     <= 1'b1;
        chars.char_code <= typed_chars.pop_front();
      end else begin
        chars.valid <= 1'b0;
      end
    end
  end

  // Receiver. Ready is rolled afresh every cycle.
  always @(posedge clk) begin
    if (rst) results.ready <= 1'b0;
    else     results.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Monitor. Both channels are sampled at the same edge. The result side is
  // checked before the character side is predicted; since the parser
  // registers its result, a result can never belong to a character accepted
  // at the same edge.
  always @(posedge clk) begin
    char_result_t got;
    char_result_t want;
    if (rst) begin
      line_pos      <= LS_IDLE;
      hour_acc      <= '0;
      minute_acc    <= '0;
      second_acc    <= '0;
      tenth_acc     <= '0;
      watch_running <= 1'b0;
      quiet_cycles  <= 0;
      pending_results.delete();
    end else begin
      if (results.valid === 1'b1 && results.ready) begin
        got.command    = results.command;
        got.hour       = results.set_hour;
        got.minute     = results.set_minute;
        got.second     = results.set_second;
        got.tenth      = results.set_tenth;
        got.stop       = results.stop_stopwatch;
        got.line_valid = results.line_valid;
        if (pending_results.size() == 0) begin
          report_error("result transaction with no character waiting for it");
        end else begin
          want = pending_results.pop_front();
          check_field("command", 8'(got.command), 8'(want.command));
          check_field("set_hour", 8'(got.hour), 8'(want.hour));
          check_field("set_minute", 8'(got.minute), 8'(want.minute));
          check_field("set_second", 8'(got.second), 8'(want.second));
          check_field("set_tenth", 8'(got.tenth), 8'(want.tenth));
          check_field("stop_stopwatch", 8'(got.stop), 8'(want.stop));
          check_field("line_valid", 8'(got.line_valid), 8'(want.line_valid));
        end
      end
      if (chars.valid && chars.ready)
        pending_results.push_back(parse_char(chars.char_code));
      if ((chars.valid && chars.ready) || (results.valid === 1'b1 && results.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: gives up when the channels have been silent for too long.
  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and end of run. Four idling phases run in turn: none, sender
  // idle, receiver stalling, and both at once. Each phase waits until every
  // character is through and every result has been checked.
  initial begin
    int phase;
    chars.valid        = 1'b0;
    chars.char_code    = 8'h00;
    results.ready      = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    error_count        = 0;
    quiet_cycles       = 0;
    rst                = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < 4; phase++) begin
      // Fill the queue away from the rising edge so the sender never races it.
      @(negedge clk);
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 54;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 54;
        end
        default: begin
          sender_idle_pct    = 29;
          receiver_stall_pct = 29;
        end
      endcase
      if (phase == 0) begin
        // Start the stopwatch in mixed case, then stop it with a high byte
        // that also spoils the line.
        queue_text("gO");
        typed_chars.push_back(CH_CR);
        typed_chars.push_back(8'hFF);
        typed_chars.push_back(CH_CR);
        // Set the clock to its largest legal value.
        queue_text("SeT 2359599");
        typed_chars.push_back(CH_CR);
        // A complete command followed by one character too many.
        queue_text("time!");
        typed_chars.push_back(CH_CR);
        // A zero byte, and a bare carriage return on an empty line.
        typed_chars.push_back(8'h00);
        typed_chars.push_back(CH_CR);
      end
      while (typed_chars.size() < PHASE_CHARS) queue_random_line();
      while (typed_chars.size() != 0 || chars.valid || pending_results.size() != 0)
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ clock_command_parser_top.f @@
src/ccp_pkg.sv
src/ccp_char_if.sv
src/ccp_result_if.sv
src/clock_command_parser_top.sv
bench/tb_clock_command_parser_top.sv
